// ----- rtl/tcw_pkg.sv -----
// Package for the text console writer: screen geometry, codes, shared types
// and cell address helpers. No dependencies.
package tcw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int CELL_DEPTH     = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int ADDR_W         = $clog2(CELL_DEPTH);
  localparam int CELL_W         = 16;

  localparam int REQ_W      = 2;
  localparam int BYTE_W     = 8;
  localparam int POS_X_W    = 8;
  localparam int POS_Y_W    = 6;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int LIN_W      = 11;
  localparam int LIN_FULL_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;

  localparam logic [BYTE_W-1:0] NEWLINE_CODE    = 8'h0a;
  localparam logic [BYTE_W-1:0] SPACE_CODE      = 8'h20;
  localparam logic [COL_W-1:0]  LAST_SCREEN_COL = COL_W'(SCREEN_COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_SCREEN_ROW = ROW_W'(SCREEN_ROWS - 1);

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT    = 2'd0,
    REQ_SETPOS = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_READ   = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_COL = 3'd0,
    CFG_LAST_COL  = 3'd1,
    CFG_FIRST_ROW = 3'd2,
    CFG_LAST_ROW  = 3'd3,
    CFG_HW_CURSOR = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_SCROLL,
    ST_FILL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [COL_W-1:0] first_col;
    logic [COL_W-1:0] last_col;
    logic [ROW_W-1:0] first_row;
    logic [ROW_W-1:0] last_row;
    logic             hw_cursor_en;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    first_col:    '0,
    last_col:     LAST_SCREEN_COL,
    first_row:    '0,
    last_row:     LAST_SCREEN_ROW,
    hw_cursor_en: 1'b1
  };

  typedef struct packed {
    logic [COL_W-1:0]  cursor_x;
    logic [ROW_W-1:0]  cursor_y;
    logic [LIN_W-1:0]  cursor_linear;
    logic              scrolled;
    logic              pos_rejected;
    logic [BYTE_W-1:0] read_char;
    logic [BYTE_W-1:0] read_attr;
  } res_t;

  function automatic logic [LIN_FULL_W-1:0] screen_pos(input logic [COL_W-1:0] col,
                                                       input logic [ROW_W-1:0] row);
    return LIN_FULL_W'(row) * LIN_FULL_W'(SCREEN_COLUMNS) + LIN_FULL_W'(col);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row);
    logic [LIN_FULL_W-1:0] lin;
    lin = screen_pos(col, row);
    return lin[ADDR_W-1:0];
  endfunction

  function automatic logic [LIN_W-1:0] cursor_lin(input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] row);
    logic [LIN_FULL_W-1:0] lin;
    lin = screen_pos(col, row);
    return lin[LIN_W-1:0];
  endfunction

endpackage

// ----- rtl/tcw_req_if.sv -----
// Request channel of the text console writer: valid/ready plus request fields.
// Depends on tcw_pkg for field widths.
interface tcw_req_if import tcw_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic [BYTE_W-1:0]         char_code;
  logic [BYTE_W-1:0]         attr;
  logic signed [POS_X_W-1:0] pos_x;
  logic signed [POS_Y_W-1:0] pos_y;

  modport source (output valid, req_type, char_code, attr, pos_x, pos_y, input ready);
  modport sink   (input valid, req_type, char_code, attr, pos_x, pos_y, output ready);
endinterface

// ----- rtl/tcw_res_if.sv -----
// Result channel of the text console writer: valid/ready plus result fields.
// Depends on tcw_pkg for field widths.
interface tcw_res_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  cursor_x;
  logic [ROW_W-1:0]  cursor_y;
  logic [LIN_W-1:0]  cursor_linear;
  logic              scrolled;
  logic              pos_rejected;
  logic [BYTE_W-1:0] read_char;
  logic [BYTE_W-1:0] read_attr;

  modport source (output valid, cursor_x, cursor_y, cursor_linear, scrolled, pos_rejected,
                  read_char, read_attr, input ready);
  modport sink   (input valid, cursor_x, cursor_y, cursor_linear, scrolled, pos_rejected,
                  read_char, read_attr, output ready);
endinterface

// ----- rtl/tcw_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/tcw_ctrl.sv -----
// Request sequencer: cursor, position resolve, put/scroll/clear/read sweeps over
// the cell store. Depends on tcw_pkg and tcw_req_if; drives the cell RAM ports.
module tcw_ctrl import tcw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  tcw_req_if.sink           in_ch,
  input  logic              out_free,
  output logic              res_load,
  output res_t              res,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [CELL_W-1:0] ram_wdata,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [CELL_W-1:0] ram_rdata
);

  state_t state_r, state_nxt;

  // latched request
  req_t               req_r;
  logic [BYTE_W-1:0]  char_r, attr_r;
  logic [POS_X_W-1:0] px_r;
  logic [POS_Y_W-1:0] py_r;

  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0] cur_row_r, cur_row_nxt;

  // result held across a sweep
  logic [COL_W-1:0] res_col_r, res_col_nxt;
  logic [ROW_W-1:0] res_row_r, res_row_nxt;
  logic             res_upd_r, res_upd_nxt;
  logic             res_scr_r, res_scr_nxt;
  logic             res_rej_r, res_rej_nxt;

  // sweep walker
  logic [COL_W-1:0]  sw_col_r, sw_col_nxt;
  logic [ROW_W-1:0]  sw_row_r, sw_row_nxt;
  logic [ROW_W-1:0]  sw_row_end_r, sw_row_end_nxt;
  logic              pend_r, pend_nxt;
  logic [ADDR_W-1:0] pend_addr_r, pend_addr_nxt;
  logic              issue_done_r, issue_done_nxt;
  logic [CELL_W-1:0] fill_data_r, fill_data_nxt;

  // window bounds clipped to the screen
  logic [COL_W-1:0] col_hi;
  logic [ROW_W-1:0] row_lim;
  logic [ROW_W-1:0] copy_hi;
  logic             cols_ok, copy_ok, lastfill_ok, clear_ok, home_ok;

  // request evaluation
  logic [9:0]       rx;
  logic [7:0]       ry;
  logic             pos_ok;
  logic [7:0]       pc;
  logic [5:0]       pr;
  logic             put_we, need_scroll;
  logic [COL_W-1:0] exec_col;
  logic [ROW_W-1:0] exec_row;
  logic             exec_upd, exec_scr, exec_rej;

  logic             finish_now;
  logic             sw_last_col, sw_last;
  logic [COL_W-1:0] sel_col;
  logic [ROW_W-1:0] sel_row;
  logic             sel_upd, sel_scr, sel_rej;
  logic [COL_W-1:0] fin_col;
  logic [ROW_W-1:0] fin_row;

  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    col_hi      = (cfg.last_col > LAST_SCREEN_COL) ? LAST_SCREEN_COL : cfg.last_col;
    row_lim     = (cfg.last_row > LAST_SCREEN_ROW) ? LAST_SCREEN_ROW : cfg.last_row;
    copy_hi     = row_lim - ROW_W'(1);
    cols_ok     = cfg.first_col <= col_hi;
    copy_ok     = cols_ok && (cfg.last_row != '0) && (cfg.first_row <= copy_hi);
    lastfill_ok = cols_ok && (cfg.last_row <= LAST_SCREEN_ROW);
    clear_ok    = cols_ok && (cfg.first_row <= row_lim);
    home_ok     = (cfg.first_col <= cfg.last_col) && (cfg.first_row <= cfg.last_row) &&
                  (cfg.first_col <= LAST_SCREEN_COL) && (cfg.first_row <= LAST_SCREEN_ROW);
  end

  // position resolve: negative coordinates count back from the last column/row
  always_comb begin
    rx = {{2{px_r[POS_X_W-1]}}, px_r};
    if (px_r[POS_X_W-1]) begin
      rx = rx + {3'b000, cfg.last_col};
    end
    ry = {{2{py_r[POS_Y_W-1]}}, py_r};
    if (py_r[POS_Y_W-1]) begin
      ry = ry + {3'b000, cfg.last_row};
    end
    pos_ok = !rx[9] && (rx[8:0] >= {2'b00, cfg.first_col}) &&
             (rx[8:0] <= {2'b00, cfg.last_col}) && (rx[8:0] <= {2'b00, LAST_SCREEN_COL}) &&
             !ry[7] && (ry[6:0] >= {2'b00, cfg.first_row}) &&
             (ry[6:0] <= {2'b00, cfg.last_row}) && (ry[6:0] <= {2'b00, LAST_SCREEN_ROW});
  end

  // put character: write at cursor, advance, wrap, detect scroll; a newline writes nothing and moves to the next row
  always_comb begin
    pc     = {1'b0, cur_col_r};
    pr     = {1'b0, cur_row_r};
    put_we = 1'b0;
    if (char_r == NEWLINE_CODE) begin
      pc = {1'b0, cfg.first_col};
      pr = pr + 6'd1;
    end else begin
      put_we = (cur_col_r <= cfg.last_col) && (cur_row_r <= cfg.last_row) &&
               (cur_col_r <= LAST_SCREEN_COL) && (cur_row_r <= LAST_SCREEN_ROW);
      pc = pc + 8'd1;
      if (pc > {1'b0, cfg.last_col}) begin
        pc = {1'b0, cfg.first_col};
        pr = pr + 6'd1;
      end
    end
    need_scroll = pr > {1'b0, cfg.last_row};
    if (need_scroll) begin
      pr = {1'b0, cfg.last_row};
    end
  end

  always_comb begin
    exec_col = cur_col_r;
    exec_row = cur_row_r;
    exec_upd = 1'b0;
    exec_scr = 1'b0;
    exec_rej = 1'b0;
    case (req_r)
      REQ_PUT: begin
        exec_col = pc[COL_W-1:0];
        exec_row = pr[ROW_W-1:0];
        exec_upd = 1'b1;
        exec_scr = need_scroll;
      end
      REQ_SETPOS: begin
        exec_col = rx[COL_W-1:0];
        exec_row = ry[ROW_W-1:0];
        exec_upd = pos_ok;
        exec_rej = !pos_ok;
      end
      REQ_CLEAR: begin
        exec_col = cfg.first_col;
        exec_row = cfg.first_row;
        exec_upd = home_ok;
        exec_rej = !home_ok;
      end
      REQ_READ: begin
        exec_rej = !pos_ok;
      end
      default: begin
        exec_rej = 1'b0;
      end
    endcase
  end

  // result source: straight from evaluation in EXEC, from held regs in the later states
  always_comb begin
    if (state_r == ST_EXEC) begin
      sel_col = exec_col;
      sel_row = exec_row;
      sel_upd = exec_upd;
      sel_scr = exec_scr;
      sel_rej = exec_rej;
    end else begin
      sel_col = res_col_r;
      sel_row = res_row_r;
      sel_upd = res_upd_r;
      sel_scr = res_scr_r;
      sel_rej = res_rej_r;
    end
    fin_col = sel_upd ? sel_col : cur_col_r;
    fin_row = sel_upd ? sel_row : cur_row_r;

    res.cursor_x      = fin_col;
    res.cursor_y      = fin_row;
    res.cursor_linear = cfg.hw_cursor_en ? cursor_lin(fin_col, fin_row) : '0;
    res.scrolled      = sel_scr;
    res.pos_rejected  = sel_rej;
    res.read_char     = (state_r == ST_RDATA) ? ram_rdata[BYTE_W-1:0] : '0;
    res.read_attr     = (state_r == ST_RDATA) ? ram_rdata[CELL_W-1:BYTE_W] : '0;
  end

  assign sw_last_col = (sw_col_r == col_hi);
  assign sw_last     = sw_last_col && (sw_row_r == sw_row_end_r);

  always_comb begin
    state_nxt      = state_r;
    cur_col_nxt    = cur_col_r;
    cur_row_nxt    = cur_row_r;
    res_col_nxt    = res_col_r;
    res_row_nxt    = res_row_r;
    res_upd_nxt    = res_upd_r;
    res_scr_nxt    = res_scr_r;
    res_rej_nxt    = res_rej_r;
    sw_col_nxt     = sw_col_r;
    sw_row_nxt     = sw_row_r;
    sw_row_end_nxt = sw_row_end_r;
    pend_nxt       = pend_r;
    pend_addr_nxt  = pend_addr_r;
    issue_done_nxt = issue_done_r;
    fill_data_nxt  = fill_data_r;
    finish_now     = 1'b0;
    res_load       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = cell_addr(cur_col_r, cur_row_r);
    ram_wdata      = {attr_r, char_r};
    ram_raddr      = cell_addr(rx[COL_W-1:0], ry[ROW_W-1:0]);

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        res_col_nxt = exec_col;
        res_row_nxt = exec_row;
        res_upd_nxt = exec_upd;
        res_scr_nxt = exec_scr;
        res_rej_nxt = exec_rej;
        case (req_r)
          REQ_PUT: begin
            ram_we = put_we;
            if (need_scroll) begin
              fill_data_nxt = {attr_r, SPACE_CODE};
              sw_col_nxt    = cfg.first_col;
              if (copy_ok) begin
                sw_row_nxt     = cfg.first_row;
                sw_row_end_nxt = copy_hi;
                pend_nxt       = 1'b0;
                issue_done_nxt = 1'b0;
                state_nxt      = ST_SCROLL;
              end else if (lastfill_ok) begin
                sw_row_nxt     = cfg.last_row;
                sw_row_end_nxt = cfg.last_row;
                state_nxt      = ST_FILL;
              end else begin
                state_nxt = ST_FINISH;
              end
            end else begin
              finish_now = 1'b1;
            end
          end
          REQ_CLEAR: begin
            if (clear_ok) begin
              fill_data_nxt  = {attr_r, char_r};
              sw_col_nxt     = cfg.first_col;
              sw_row_nxt     = cfg.first_row;
              sw_row_end_nxt = row_lim;
              state_nxt      = ST_FILL;
            end else begin
              finish_now = 1'b1;
            end
          end
          REQ_READ: begin
            if (pos_ok) begin
              state_nxt = ST_RDATA;
            end else begin
              finish_now = 1'b1;
            end
          end
          default: begin
            finish_now = 1'b1;
          end
        endcase
        if (finish_now && out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_RDATA: begin
        // read address still driven from the held request, so data stays put
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_SCROLL: begin
        // read row below, write it in the following cycle into the row above
        ram_we    = pend_r;
        ram_waddr = pend_addr_r;
        ram_wdata = ram_rdata;
        ram_raddr = cell_addr(sw_col_r, sw_row_r + ROW_W'(1));
        if (!issue_done_r) begin
          pend_nxt      = 1'b1;
          pend_addr_nxt = cell_addr(sw_col_r, sw_row_r);
          if (sw_last_col) begin
            sw_col_nxt = cfg.first_col;
            if (sw_row_r == sw_row_end_r) begin
              issue_done_nxt = 1'b1;
            end else begin
              sw_row_nxt = sw_row_r + ROW_W'(1);
            end
          end else begin
            sw_col_nxt = sw_col_r + COL_W'(1);
          end
        end else begin
          pend_nxt = 1'b0;
          if (lastfill_ok) begin
            sw_col_nxt     = cfg.first_col;
            sw_row_nxt     = cfg.last_row;
            sw_row_end_nxt = cfg.last_row;
            state_nxt      = ST_FILL;
          end else begin
            state_nxt = ST_FINISH;
          end
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = cell_addr(sw_col_r, sw_row_r);
        ram_wdata = fill_data_r;
        if (sw_last) begin
          state_nxt = ST_FINISH;
        end else if (sw_last_col) begin
          sw_col_nxt = cfg.first_col;
          sw_row_nxt = sw_row_r + ROW_W'(1);
        end else begin
          sw_col_nxt = sw_col_r + COL_W'(1);
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (res_load && sel_upd) begin
      cur_col_nxt = sel_col;
      cur_row_nxt = sel_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      pend_r       <= 1'b0;
      issue_done_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_col_r    <= cur_col_nxt;
      cur_row_r    <= cur_row_nxt;
      pend_r       <= pend_nxt;
      issue_done_r <= issue_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_r  <= req_t'(in_ch.req_type);
      char_r <= in_ch.char_code;
      attr_r <= in_ch.attr;
      px_r   <= in_ch.pos_x;
      py_r   <= in_ch.pos_y;
    end
    res_col_r    <= res_col_nxt;
    res_row_r    <= res_row_nxt;
    res_upd_r    <= res_upd_nxt;
    res_scr_r    <= res_scr_nxt;
    res_rej_r    <= res_rej_nxt;
    sw_col_r     <= sw_col_nxt;
    sw_row_r     <= sw_row_nxt;
    sw_row_end_r <= sw_row_end_nxt;
    pend_addr_r  <= pend_addr_nxt;
    fill_data_r  <= fill_data_nxt;
  end

endmodule

// ----- rtl/text_console_writer_top.sv -----
// Text console writer top level: configuration registers, result register,
// cell store RAM and request sequencer. Depends on tcw_pkg, tcw_req_if,
// tcw_res_if, tcw_ram and tcw_ctrl.
//
// Handles one request at a time over an 80x25 store of 16-bit cells
// (character low byte, attribute high byte) held in a single RAM with one
// write and one registered read port. A scroll walks the window through the
// RAM one cell per cycle and a clear writes one cell per cycle; both rates
// are set by the single write port of the cell store. Cells read back before
// they were ever written or cleared return unspecified data; no clearing pass
// runs after reset. The result register lets the next request be taken while
// the previous result waits; configuration writes belong in idle periods only.
module text_console_writer_top import tcw_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tcw_req_if.sink               in_ch,
  tcw_res_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r, cfg_nxt;
  logic out_valid_r, out_valid_nxt;
  res_t out_data_r;

  logic              out_free;
  logic              res_load;
  res_t              res;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        CFG_FIRST_COL: cfg_nxt.first_col    = cfg_wdata[COL_W-1:0];
        CFG_LAST_COL:  cfg_nxt.last_col     = cfg_wdata[COL_W-1:0];
        CFG_FIRST_ROW: cfg_nxt.first_row    = cfg_wdata[ROW_W-1:0];
        CFG_LAST_ROW:  cfg_nxt.last_row     = cfg_wdata[ROW_W-1:0];
        CFG_HW_CURSOR: cfg_nxt.hw_cursor_en = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cursor_x      = out_data_r.cursor_x;
  assign out_ch.cursor_y      = out_data_r.cursor_y;
  assign out_ch.cursor_linear = out_data_r.cursor_linear;
  assign out_ch.scrolled      = out_data_r.scrolled;
  assign out_ch.pos_rejected  = out_data_r.pos_rejected;
  assign out_ch.read_char     = out_data_r.read_char;
  assign out_ch.read_attr     = out_data_r.read_attr;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .out_free  (out_free),
    .res_load  (res_load),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// ----- rtl/tcw_checker.sv -----
// Port-level checks for the text console writer, bound to the top level.
// Depends on tcw_pkg for field widths.
module tcw_checker import tcw_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [COL_W-1:0]  out_cursor_x,
  input logic [ROW_W-1:0]  out_cursor_y,
  input logic              out_scrolled,
  input logic              out_pos_rejected,
  input logic [BYTE_W-1:0] out_read_char,
  input logic [BYTE_W-1:0] out_read_attr
);

  // one item in flight: ready drops right after an item is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("tcw: ready held after accepting an item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cursor_x) && $stable(out_cursor_y))
    else $error("tcw: stalled result changed");

  // scrolling comes only from put character, refusal never does
  a_scroll_no_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_scrolled && out_pos_rejected))
    else $error("tcw: result both scrolled and rejected");

  a_scroll_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_scrolled || out_pos_rejected) |->
      out_read_char == '0 && out_read_attr == '0)
    else $error("tcw: cell data on a non-read result");

endmodule

bind text_console_writer_top tcw_checker u_tcw_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_cursor_x     (out_ch.cursor_x),
  .out_cursor_y     (out_ch.cursor_y),
  .out_scrolled     (out_ch.scrolled),
  .out_pos_rejected (out_ch.pos_rejected),
  .out_read_char    (out_ch.read_char),
  .out_read_attr    (out_ch.read_attr)
);
